[design/supply_voltage_supervisor_core_defines.svh]
// ----------------------------------------------------------------------------
// Supply voltage supervisor assertion macros
// Shared assertion shorthands for the supervisor's checker.
// ----------------------------------------------------------------------------
`ifndef SUPPLY_VOLTAGE_SUPERVISOR_CORE_DEFINES_SVH
`define SUPPLY_VOLTAGE_SUPERVISOR_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SVS_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: implication failed");

// next-cycle implication, disabled during reset
`define SVS_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication failed");

`endif

[design/svs_pkg.sv]
// ----------------------------------------------------------------------------
// Supply voltage supervisor package
// Command codes, register indexes, widths and reset values.
// ----------------------------------------------------------------------------
package svs_pkg;

  localparam int unsigned SAMPLE_BITS_DEF = 12;
  localparam int unsigned CFG_DATA_W      = 16;
  localparam int unsigned CFG_IDX_W       = 3;
  localparam int unsigned TIME_W          = 16;
  localparam int unsigned DIAG_W          = 2;

  // item command
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_UNDER_TRIP    = 3'd0,
    REG_UNDER_WARN    = 3'd1,
    REG_UNDER_RELEASE = 3'd2,
    REG_OVER_RELEASE  = 3'd3,
    REG_OVER_WARN     = 3'd4,
    REG_OVER_TRIP     = 3'd5,
    REG_DETECT_TIME   = 3'd6
  } reg_idx_e;

  // diag bit positions
  localparam int unsigned DIAG_UNDER_BIT = 0;
  localparam int unsigned DIAG_OVER_BIT  = 1;

  // register reset values
  localparam logic [CFG_DATA_W-1:0] UNDER_TRIP_RST    = 16'd1200;
  localparam logic [CFG_DATA_W-1:0] UNDER_WARN_RST    = 16'd1450;
  localparam logic [CFG_DATA_W-1:0] UNDER_RELEASE_RST = 16'd1550;
  localparam logic [CFG_DATA_W-1:0] OVER_RELEASE_RST  = 16'd2750;
  localparam logic [CFG_DATA_W-1:0] OVER_WARN_RST     = 16'd2850;
  localparam logic [CFG_DATA_W-1:0] OVER_TRIP_RST     = 16'd3100;
  localparam logic [TIME_W-1:0]     DETECT_TIME_RST   = 16'd1000;

endpackage

[design/supply_voltage_supervisor_core.sv]
// ----------------------------------------------------------------------------
// Supply voltage supervisor core
// Window monitor with hard trips, shared debounce timer and hysteresis
// release on a stream of converter samples and millisecond ticks.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------
//  in      | sink      | in_valid_i/in_stall_o  | cmd, voltage_sample, sample_valid
//  out     | source    | out_valid_o/out_stall_i| trip, stop, start, clear, faults, diag
//  cfg     | sink      | cfg_we_i             | cfg_idx_i, cfg_wdata_i
//
//  One item per cycle while in_stall_o is low; the result shows on the cycle after acceptance.
//  in_stall_o is high only while a result sits in the output register and
//  the downstream side stalls; a draining result frees the slot the same cycle.
//  Reset clears all supervisor state and loads the register defaults.
// ----------------------------------------------------------------------------
module supply_voltage_supervisor_core #(
  parameter int unsigned SAMPLE_BITS = svs_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,

  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [svs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [svs_pkg::CFG_DATA_W-1:0] cfg_wdata_i,

  // input items
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           cmd_i,
  input  logic [SAMPLE_BITS-1:0]         voltage_sample_i,
  input  logic                           sample_valid_i,

  // result items
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           immediate_trip_o,
  output logic                           stop_motor_o,
  output logic                           protection_start_o,
  output logic                           protection_clear_o,
  output logic                           under_fault_o,
  output logic                           over_fault_o,
  output logic [svs_pkg::DIAG_W-1:0]     diag_bits_o
);

  localparam int unsigned TW = svs_pkg::TIME_W;
  localparam int unsigned DW = svs_pkg::DIAG_W;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [SAMPLE_BITS-1:0] under_trip_q, under_warn_q, under_rel_q;
  logic [SAMPLE_BITS-1:0] over_rel_q, over_warn_q, over_trip_q;
  logic [TW-1:0]          detect_time_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      under_trip_q  <= SAMPLE_BITS'(svs_pkg::UNDER_TRIP_RST);
      under_warn_q  <= SAMPLE_BITS'(svs_pkg::UNDER_WARN_RST);
      under_rel_q   <= SAMPLE_BITS'(svs_pkg::UNDER_RELEASE_RST);
      over_rel_q    <= SAMPLE_BITS'(svs_pkg::OVER_RELEASE_RST);
      over_warn_q   <= SAMPLE_BITS'(svs_pkg::OVER_WARN_RST);
      over_trip_q   <= SAMPLE_BITS'(svs_pkg::OVER_TRIP_RST);
      detect_time_q <= svs_pkg::DETECT_TIME_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        svs_pkg::REG_UNDER_TRIP:    under_trip_q  <= cfg_wdata_i[SAMPLE_BITS-1:0];
        svs_pkg::REG_UNDER_WARN:    under_warn_q  <= cfg_wdata_i[SAMPLE_BITS-1:0];
        svs_pkg::REG_UNDER_RELEASE: under_rel_q   <= cfg_wdata_i[SAMPLE_BITS-1:0];
        svs_pkg::REG_OVER_RELEASE:  over_rel_q    <= cfg_wdata_i[SAMPLE_BITS-1:0];
        svs_pkg::REG_OVER_WARN:     over_warn_q   <= cfg_wdata_i[SAMPLE_BITS-1:0];
        svs_pkg::REG_OVER_TRIP:     over_trip_q   <= cfg_wdata_i[SAMPLE_BITS-1:0];
        svs_pkg::REG_DETECT_TIME:   detect_time_q <= cfg_wdata_i[TW-1:0];
        default: ; // unmapped index: write dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake: the output register is the only buffer. A new item enters
  // when the slot is empty or its result leaves this cycle.
  // --------------------------------------------------------------------------
  logic out_valid_q;
  logic in_accept;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_accept  = in_valid_i & ~in_stall_o;

  // --------------------------------------------------------------------------
  // Supervisor state
  // --------------------------------------------------------------------------
  logic          under_lat_q, under_lat_d;
  logic          over_lat_q, over_lat_d;
  logic          under_pend_q, under_pend_d;
  logic          over_pend_q, over_pend_d;
  logic [TW-1:0] dbc_cnt_q, dbc_cnt_d;
  logic          dbc_run_q, dbc_run_d;
  logic          prot_act_q, prot_act_d;
  logic [DW-1:0] sticky_q, sticky_d;

  logic trip_d, stop_d, start_d, clear_d;

  // Step rule. The under side runs first; its timer updates are seen by the
  // over side in the same item since both share one debounce counter.
  always_comb begin
    under_lat_d  = under_lat_q;
    over_lat_d   = over_lat_q;
    under_pend_d = under_pend_q;
    over_pend_d  = over_pend_q;
    dbc_cnt_d    = dbc_cnt_q;
    dbc_run_d    = dbc_run_q;
    prot_act_d   = prot_act_q;
    sticky_d     = sticky_q;
    trip_d       = 1'b0;
    stop_d       = 1'b0;
    start_d      = 1'b0;
    clear_d      = 1'b0;

    if (cmd_i == svs_pkg::CMD_TICK) begin
      // ms tick: advance the debounce timer, saturating
      if (dbc_run_q && (dbc_cnt_q != {TW{1'b1}})) begin
        dbc_cnt_d = dbc_cnt_q + TW'(1);
      end
    end else if (sample_valid_i && (voltage_sample_i != '0)) begin
      if (voltage_sample_i <= under_trip_q) begin
        // hard under-voltage trip, over side skipped
        stop_d      = 1'b1;
        under_lat_d = 1'b1;
        trip_d      = 1'b1;
      end else begin
        // under-voltage side
        if (under_lat_q) begin
          if (voltage_sample_i >= under_rel_q) begin
            under_lat_d  = 1'b0;
            under_pend_d = 1'b0;
            dbc_cnt_d    = '0;
            dbc_run_d    = 1'b0;
            prot_act_d   = 1'b0;
            clear_d      = 1'b1;
          end
        end else if (voltage_sample_i <= under_warn_q) begin
          if (!under_pend_q) begin
            under_pend_d = 1'b1;
            dbc_cnt_d    = '0;
            dbc_run_d    = 1'b1;
          end
          if (dbc_cnt_d >= detect_time_q) begin
            under_lat_d                      = 1'b1;
            sticky_d[svs_pkg::DIAG_UNDER_BIT] = 1'b1;
            stop_d                           = 1'b1;
            if (!prot_act_d) begin
              prot_act_d = 1'b1;
              start_d    = 1'b1;
            end
            dbc_cnt_d = detect_time_q;
            dbc_run_d = 1'b0;
          end
        end else if (under_pend_q) begin
          under_pend_d = 1'b0;
          dbc_cnt_d    = '0;
          dbc_run_d    = 1'b0;
        end

        // over-voltage side
        if (voltage_sample_i >= over_trip_q) begin
          stop_d     = 1'b1;
          over_lat_d = 1'b1;
          trip_d     = 1'b1;
        end else if (over_lat_q) begin
          if (voltage_sample_i <= over_rel_q) begin
            over_lat_d  = 1'b0;
            over_pend_d = 1'b0;
            dbc_cnt_d   = '0;
            dbc_run_d   = 1'b0;
            prot_act_d  = 1'b0;
            clear_d     = 1'b1;
          end
        end else if (voltage_sample_i >= over_warn_q) begin
          if (!over_pend_q) begin
            over_pend_d = 1'b1;
            dbc_cnt_d   = '0;
            dbc_run_d   = 1'b1;
          end
          if (dbc_cnt_d >= detect_time_q) begin
            over_lat_d                      = 1'b1;
            sticky_d[svs_pkg::DIAG_OVER_BIT] = 1'b1;
            stop_d                          = 1'b1;
            if (!prot_act_d) begin
              prot_act_d = 1'b1;
              start_d    = 1'b1;
            end
            dbc_cnt_d = detect_time_q;
            dbc_run_d = 1'b0;
          end
        end else if (over_pend_q) begin
          over_pend_d = 1'b0;
          dbc_cnt_d   = '0;
          dbc_run_d   = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      under_lat_q  <= 1'b0;
      over_lat_q   <= 1'b0;
      under_pend_q <= 1'b0;
      over_pend_q  <= 1'b0;
      dbc_cnt_q    <= '0;
      dbc_run_q    <= 1'b0;
      prot_act_q   <= 1'b0;
      sticky_q     <= '0;
    end else if (in_accept) begin
      under_lat_q  <= under_lat_d;
      over_lat_q   <= over_lat_d;
      under_pend_q <= under_pend_d;
      over_pend_q  <= over_pend_d;
      dbc_cnt_q    <= dbc_cnt_d;
      dbc_run_q    <= dbc_run_d;
      prot_act_q   <= prot_act_d;
      sticky_q     <= sticky_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic          trip_q, stop_q, start_q, clear_q;
  logic          ufault_q, ofault_q;
  logic [DW-1:0] diag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      trip_q   <= trip_d;
      stop_q   <= stop_d;
      start_q  <= start_d;
      clear_q  <= clear_d;
      ufault_q <= under_lat_d;
      ofault_q <= over_lat_d;
      diag_q   <= sticky_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign immediate_trip_o   = trip_q;
  assign stop_motor_o       = stop_q;
  assign protection_start_o = start_q;
  assign protection_clear_o = clear_q;
  assign under_fault_o      = ufault_q;
  assign over_fault_o       = ofault_q;
  assign diag_bits_o        = diag_q;

endmodule

[design/svs_checker.sv]
// ----------------------------------------------------------------------------
// Supply voltage supervisor checker
// Port-level assertions on the supervisor core, bound into every core instance.
// ----------------------------------------------------------------------------
`include "supply_voltage_supervisor_core_defines.svh"

module svs_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic                       immediate_trip_o,
  input logic                       stop_motor_o,
  input logic                       protection_start_o,
  input logic                       under_fault_o,
  input logic                       over_fault_o,
  input logic [svs_pkg::DIAG_W-1:0] diag_bits_o
);

  // a stalled result stays and holds its payload
  `SVS_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
                  out_valid_o && $stable(stop_motor_o) && $stable(diag_bits_o))

  // the input side stalls only behind a stalled result
  `SVS_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)

  // a hard trip always requests a motor stop and leaves a fault latched
  `SVS_ASSERT_IMP(a_trip_stop, clk_i, rst_ni, out_valid_o && immediate_trip_o,
                  stop_motor_o && (under_fault_o || over_fault_o))

  // entering protection comes with a stop, a latched fault and a sticky code
  `SVS_ASSERT_IMP(a_start_fault, clk_i, rst_ni, out_valid_o && protection_start_o,
                  stop_motor_o && (under_fault_o || over_fault_o) && (diag_bits_o != '0))

endmodule

bind supply_voltage_supervisor_core svs_checker u_svs_checker (.*);
